// ===== hdl/mcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfd_pkg
// types and constants shared by the motor command frame decoder modules
// ----------------------------------------------------------------------------
package mcfd_pkg;

    // number of drive outputs on the result side
    localparam int unsigned NUM_MOTORS = 6;

    // field index codes
    localparam logic [2:0] FIELDS_MAX    = 3'd6;
    localparam logic [2:0] FIDX_TEXT_END = 3'd7;

    // magnitude saturation
    localparam logic [13:0] MAG_MAX = 14'd1023;

    // duty limit after reset
    localparam logic [7:0] DUTY_LIMIT_RESET = 8'd125;

    // characters
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // parse phase of the current field
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_OPEN = 2'd1,
        PH_NUM  = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    // one parsed field value, sign and magnitude
    typedef struct packed {
        logic       neg;
        logic [9:0] mag;
    } t_field;

    // frame queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== hdl/mcfd_front.sv =====
// ----------------------------------------------------------------------------
// mcfd_front
// character parser: builds field values and hands closed frames to the queue
// ----------------------------------------------------------------------------
module mcfd_front
    import mcfd_pkg::*;
#(
    parameter int unsigned FRAME_CHARS = 30,
    parameter int unsigned MOTOR_COUNT = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [7:0]                   i_rx_byte,
    input  t_qstat                       i_qstat,
    output logic                         o_q_wr,
    output t_field [MOTOR_COUNT-1:0]     o_frame
);

    localparam int unsigned CW = $clog2(FRAME_CHARS);
    localparam logic [CW-1:0] CHAR_LAST = CW'(FRAME_CHARS - 1);

    logic [2:0]               r_field_idx, n_field_idx;
    logic [9:0]               r_mag, n_mag;
    logic                     r_neg, n_neg;
    t_phase                   r_phase, n_phase;
    logic [CW-1:0]            r_char_count, n_char_count;
    t_field [MOTOR_COUNT-1:0] r_vals, n_vals;

    logic                     w_accept;
    logic                     w_close;
    logic                     w_space;
    logic                     w_digit;
    logic                     w_sign;
    logic [13:0]              w_acc;
    logic [9:0]               w_acc_sat;
    t_phase                   w_eff_phase;
    t_field [MOTOR_COUNT-1:0] w_commit;

    assign w_accept = i_push & ~i_qstat.full;
    assign w_close  = (i_rx_byte == CHAR_STAR) || (r_char_count == CHAR_LAST);

    assign w_space = (i_rx_byte == CHAR_SPACE) || (i_rx_byte inside {[CHAR_TAB:CHAR_CR]});
    assign w_digit = i_rx_byte inside {[CHAR_ZERO:CHAR_NINE]};
    assign w_sign  = (i_rx_byte == CHAR_PLUS) || (i_rx_byte == CHAR_MINUS);

    // acc * 10 + digit, then saturate
    assign w_acc = (14'(r_mag) << 3) + (14'(r_mag) << 1) + 14'(i_rx_byte - CHAR_ZERO);
    assign w_acc_sat = (w_acc > MAG_MAX) ? 10'(MAG_MAX) : w_acc[9:0];

    // a new field opens on its first character
    assign w_eff_phase = (r_phase == PH_IDLE) ? PH_OPEN : r_phase;

    // values with the open field written in
    always_comb begin
        w_commit = r_vals;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            if (r_phase != PH_IDLE && r_field_idx == 3'(i)) begin
                w_commit[i].neg = r_neg;
                w_commit[i].mag = r_mag;
            end
        end
    end

    // next state
    always_comb begin
        n_field_idx  = r_field_idx;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_phase      = r_phase;
        n_char_count = r_char_count;
        n_vals       = r_vals;
        if (w_accept) begin
            if (w_close) begin
                n_field_idx  = '0;
                n_mag        = '0;
                n_neg        = 1'b0;
                n_phase      = PH_IDLE;
                n_char_count = '0;
                n_vals       = '0;
            end else begin
                n_char_count = r_char_count + CW'(1);
                if (r_field_idx != FIDX_TEXT_END) begin
                    if (i_rx_byte == CHAR_NUL || i_rx_byte == CHAR_COMMA) begin
                        n_vals  = w_commit;
                        n_phase = PH_IDLE;
                        n_mag   = '0;
                        n_neg   = 1'b0;
                        if (i_rx_byte == CHAR_NUL) begin
                            n_field_idx = FIDX_TEXT_END;
                        end else if (r_phase != PH_IDLE && r_field_idx < FIELDS_MAX) begin
                            n_field_idx = r_field_idx + 3'd1;
                        end
                    end else begin
                        case (w_eff_phase)
                            PH_OPEN: begin
                                if (w_space) begin
                                    n_phase = PH_OPEN;
                                end else if (w_sign) begin
                                    n_neg   = (i_rx_byte == CHAR_MINUS);
                                    n_phase = PH_NUM;
                                end else if (w_digit) begin
                                    n_mag   = w_acc_sat;
                                    n_phase = PH_NUM;
                                end else begin
                                    n_phase = PH_DONE;
                                end
                            end
                            PH_NUM: begin
                                if (w_digit) begin
                                    n_mag = w_acc_sat;
                                end else begin
                                    n_phase = PH_DONE;
                                end
                            end
                            PH_DONE: begin
                                n_phase = PH_DONE;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // outputs
    always_comb begin
        o_q_wr  = w_accept & w_close;
        o_frame = w_commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_idx  <= '0;
            r_mag        <= '0;
            r_neg        <= 1'b0;
            r_phase      <= PH_IDLE;
            r_char_count <= '0;
            r_vals       <= '0;
        end else begin
            r_field_idx  <= n_field_idx;
            r_mag        <= n_mag;
            r_neg        <= n_neg;
            r_phase      <= n_phase;
            r_char_count <= n_char_count;
            r_vals       <= n_vals;
        end
    end

endmodule

// ===== hdl/mcfd_queue.sv =====
// ----------------------------------------------------------------------------
// mcfd_queue
// two-entry queue of closed frames between parser and drive stage
// ----------------------------------------------------------------------------
module mcfd_queue
    import mcfd_pkg::*;
#(
    parameter int unsigned MOTOR_COUNT = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr,
    input  t_field [MOTOR_COUNT-1:0] i_wr_data,
    input  logic                     i_rd,
    output t_field [MOTOR_COUNT-1:0] o_rd_data,
    output t_qstat                   o_qstat
);

    localparam int unsigned DEPTH = 2;

    t_field [MOTOR_COUNT-1:0] r_mem [DEPTH];
    logic                     r_wr_ptr;
    logic                     r_rd_ptr;
    logic [1:0]               r_count;

    logic w_wr;
    logic w_rd;

    assign o_qstat.full  = (r_count == 2'(DEPTH));
    assign o_qstat.empty = (r_count == 2'd0);
    assign w_wr = i_wr & ~o_qstat.full;
    assign w_rd = i_rd & ~o_qstat.empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

// ===== hdl/mcfd_back.sv =====
// ----------------------------------------------------------------------------
// mcfd_back
// drive stage: clamps each value to the duty limit and holds the result
// ----------------------------------------------------------------------------
module mcfd_back
    import mcfd_pkg::*;
#(
    parameter int unsigned MOTOR_COUNT = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [7:0]                       i_cfg_wr_data,
    input  t_qstat                           i_qstat,
    input  t_field [MOTOR_COUNT-1:0]         i_frame,
    output logic                             o_q_rd,
    input  logic                             i_pop,
    output logic                             o_empty,
    output logic [NUM_MOTORS-1:0][7:0]       o_duty,
    output logic [NUM_MOTORS-1:0][1:0]       o_dir
);

    logic [7:0]                 r_duty_limit;
    logic                       r_valid;
    logic [NUM_MOTORS-1:0][7:0] r_duty;
    logic [NUM_MOTORS-1:0][1:0] r_dir;

    logic [NUM_MOTORS-1:0][7:0] w_duty;
    logic [NUM_MOTORS-1:0][1:0] w_dir;
    logic                       w_load;

    for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_motor
        if (g < MOTOR_COUNT) begin : g_used
            assign w_duty[g] = (i_frame[g].mag > {2'b00, r_duty_limit}) ? r_duty_limit
                                                                       : i_frame[g].mag[7:0];
            assign w_dir[g]  = (i_frame[g].mag == '0) ? DIR_STOP
                             : (i_frame[g].neg ? DIR_REV : DIR_FWD);
        end else begin : g_unused
            assign w_duty[g] = '0;
            assign w_dir[g]  = DIR_STOP;
        end
    end

    // load when the holding register is free or being emptied
    assign w_load  = ~i_qstat.empty & (~r_valid | i_pop);
    assign o_q_rd  = w_load;
    assign o_empty = ~r_valid;
    assign o_duty  = r_duty;
    assign o_dir   = r_dir;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_duty <= w_duty;
            r_dir  <= w_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_limit <= DUTY_LIMIT_RESET;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_duty_limit <= i_cfg_wr_data;
            end
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/motor_command_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// motor_command_frame_decoder
// decodes text frames of six signed decimals into six h-bridge drives
// ----------------------------------------------------------------------------
// bytes of a frame such as "-40,120, 0,+7,,300*" are pushed one per cycle
// while full is low; each '*' (or a frame reaching FRAME_CHARS-1 stored
// characters, whose next byte is dropped) closes the frame and yields one
// result: per motor a duty min(|value|, duty_limit) and a direction (0 stop,
// 1 forward, 2 reverse). fields parse like atoi, empty fields are skipped,
// magnitudes saturate at 1023 and missing fields read as zero. a result
// passes through the frame queue, which takes it when its closing byte is
// transferred, and then the output register, which loads it once free or
// being popped. full rises only while the two-entry frame queue holds two
// frames behind a result that has not been popped.
// ----------------------------------------------------------------------------
module motor_command_frame_decoder
    import mcfd_pkg::*;
#(
    parameter int unsigned FRAME_CHARS = 30,
    parameter int unsigned MOTOR_COUNT = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: duty limit
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    // input queue side
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_rx_byte,
    // result queue side
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_duty_left_front,
    output logic [7:0] o_duty_left_middle,
    output logic [7:0] o_duty_left_rear,
    output logic [7:0] o_duty_right_front,
    output logic [7:0] o_duty_right_middle,
    output logic [7:0] o_duty_right_rear,
    output logic [1:0] o_dir_left_front,
    output logic [1:0] o_dir_left_middle,
    output logic [1:0] o_dir_left_rear,
    output logic [1:0] o_dir_right_front,
    output logic [1:0] o_dir_right_middle,
    output logic [1:0] o_dir_right_rear
);

    t_qstat                     w_qstat;
    logic                       w_q_wr;
    logic                       w_q_rd;
    t_field [MOTOR_COUNT-1:0]   w_wr_frame;
    t_field [MOTOR_COUNT-1:0]   w_rd_frame;
    logic [NUM_MOTORS-1:0][7:0] w_duty;
    logic [NUM_MOTORS-1:0][1:0] w_dir;

    // input side stalls only when the frame queue has no room
    assign full = w_qstat.full;

    // parser: one transfer per cycle while full is low, emits a frame on close
    mcfd_front #(
        .FRAME_CHARS (FRAME_CHARS),
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_rx_byte (i_rx_byte),
        .i_qstat   (w_qstat),
        .o_q_wr    (w_q_wr),
        .o_frame   (w_wr_frame)
    );

    // decouples parser from the result side
    mcfd_queue #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_q_wr),
        .i_wr_data (w_wr_frame),
        .i_rd      (w_q_rd),
        .o_rd_data (w_rd_frame),
        .o_qstat   (w_qstat)
    );

    // clamp, direction and output register
    mcfd_back #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_qstat       (w_qstat),
        .i_frame       (w_rd_frame),
        .o_q_rd        (w_q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_duty        (w_duty),
        .o_dir         (w_dir)
    );

    // motor order: left front, middle, rear, then right front, middle, rear
    assign o_duty_left_front   = w_duty[0];
    assign o_duty_left_middle  = w_duty[1];
    assign o_duty_left_rear    = w_duty[2];
    assign o_duty_right_front  = w_duty[3];
    assign o_duty_right_middle = w_duty[4];
    assign o_duty_right_rear   = w_duty[5];
    assign o_dir_left_front    = w_dir[0];
    assign o_dir_left_middle   = w_dir[1];
    assign o_dir_left_rear     = w_dir[2];
    assign o_dir_right_front   = w_dir[3];
    assign o_dir_right_middle  = w_dir[4];
    assign o_dir_right_rear    = w_dir[5];

endmodule
